FILE: src/cia_pkg.sv
`default_nettype none
package cia_pkg;

  localparam int XLEN = 64;
  localparam int DIV_STEPS = XLEN;
  localparam int HALF = XLEN / 2;
  localparam int LAST = DIV_STEPS + 1;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_REM = 4'd4;
  localparam logic [3:0] OP_MAX = 4'd5;
  localparam logic [3:0] OP_EQ  = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_LE  = 4'd9;
  localparam logic [3:0] OP_GE  = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;
  localparam logic [1:0] KIND_REM  = 2'd3;

  typedef struct packed {
    logic [3:0]             opcode;
    logic signed [XLEN-1:0] left_operand;
    logic signed [XLEN-1:0] right_operand;
  } in_t;

  typedef struct packed {
    logic signed [XLEN-1:0] value;
    logic [1:0]             status;
  } out_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [XLEN-1:0] value;
    logic [1:0]      status;
    logic            neg;
    logic            sa;
    logic            sb;
    logic [XLEN-1:0] ua;
    logic [XLEN-1:0] ub;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/checked_integer_alu.sv
`default_nettype none
// Signed 64-bit ALU with overflow and divide-by-zero status. One item per cycle
// is taken and one result per cycle delivered while the result side pops. An
// item passes through the two-entry input queue, then the entry register, the
// 64-stage one-bit-per-stage divider pipeline and the output register before it
// shows on the result ports. Every item travels through that pipeline in order.
// The result at the output holds while pop is low, the whole pipeline stalls
// behind it, and the input queue keeps accepting until it fills.
module checked_integer_alu import cia_pkg::*; (
  input  var logic clk,
  input  var logic rst,
  input  var logic push,
  output var logic full,
  input  var in_t  item,
  input  var logic pop,
  output var logic empty,
  output var out_t result
);

  entry_t entry;
  entry_t head;
  logic   avail;
  logic   take;

  cia_front u_front (
    .item  (item),
    .entry (entry)
  );

  cia_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (entry),
    .full    (full),
    .rd      (take),
    .avail   (avail),
    .rd_data (head)
  );

  cia_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

FILE: src/cia_front.sv
`default_nettype none
module cia_front import cia_pkg::*; (
  input  var in_t    item,
  output var entry_t entry
);

  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] diff;
  logic            a_lt_b;
  logic            b_lt_a;

  assign a = item.left_operand;
  assign b = item.right_operand;
  assign sum = a + b;
  assign diff = a - b;
  assign a_lt_b = item.left_operand < item.right_operand;
  assign b_lt_a = item.right_operand < item.left_operand;

  always_comb begin
    entry = '0;
    entry.sa = a[XLEN-1];
    entry.sb = b[XLEN-1];
    entry.ua = a[XLEN-1] ? (~a + 1'b1) : a;
    entry.ub = b[XLEN-1] ? (~b + 1'b1) : b;
    entry.neg = (a[XLEN-1] ^ b[XLEN-1]) && (a != '0) && (b != '0);
    entry.kind = KIND_DONE;
    entry.status = ST_OK;
    case (item.opcode)
      OP_ADD: begin
        if ((a[XLEN-1] == b[XLEN-1]) && (sum[XLEN-1] != a[XLEN-1])) entry.status = ST_OVF;
        else entry.value = sum;
      end
      OP_SUB: begin
        if ((a[XLEN-1] != b[XLEN-1]) && (diff[XLEN-1] != a[XLEN-1])) entry.status = ST_OVF;
        else entry.value = diff;
      end
      OP_MUL: entry.kind = KIND_MUL;
      OP_DIV, OP_REM: begin
        if (b == '0) entry.status = ST_DIVZ;
        else entry.kind = (item.opcode == OP_DIV) ? KIND_DIV : KIND_REM;
      end
      OP_MAX: entry.value = b_lt_a ? a : b;
      OP_EQ:  entry.value = {{(XLEN-1){1'b0}}, a == b};
      OP_LT:  entry.value = {{(XLEN-1){1'b0}}, a_lt_b};
      OP_GT:  entry.value = {{(XLEN-1){1'b0}}, b_lt_a};
      OP_LE:  entry.value = {{(XLEN-1){1'b0}}, !b_lt_a};
      OP_GE:  entry.value = {{(XLEN-1){1'b0}}, !a_lt_b};
      default: entry.value = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/cia_queue.sv
`default_nettype none
module cia_queue import cia_pkg::*; (
  input  var logic   clk,
  input  var logic   rst,
  input  var logic   wr,
  input  var entry_t wr_data,
  output var logic   full,
  input  var logic   rd,
  output var logic   avail,
  output var entry_t rd_data
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full = count == 2'd2;
  assign avail = count != 2'd0;
  assign rd_data = slots[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule
`default_nettype wire

FILE: src/cia_back.sv
`default_nettype none
module cia_back import cia_pkg::*; (
  input  var logic   clk,
  input  var logic   rst,
  input  var logic   avail,
  input  var entry_t head,
  output var logic   take,
  output var logic   empty,
  input  var logic   pop,
  output var out_t   result
);

  typedef struct packed {
    logic            valid;
    logic [1:0]      kind;
    logic [XLEN-1:0] value;
    logic [1:0]      status;
    logic            neg;
    logic            sa;
    logic            sb;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] q;
    logic [XLEN-1:0] d;
  } stage_t;

  stage_t          p [LAST+1];
  logic [XLEN-1:0] ll, lh, hl, hh;
  logic [XLEN-1:0] m_hi, m_lo;
  logic            adv;

  assign adv = !p[LAST].valid || pop;
  assign take = adv;
  assign empty = !p[LAST].valid;
  assign result.value = p[LAST].value;
  assign result.status = p[LAST].status;

  always_ff @(posedge clk) begin
    if (rst) begin
      p[0].valid <= 1'b0;
    end else if (adv) begin
      p[0].valid <= avail;
    end
    if (adv) begin
      p[0].kind <= head.kind;
      p[0].value <= head.value;
      p[0].status <= head.status;
      p[0].neg <= head.neg;
      p[0].sa <= head.sa;
      p[0].sb <= head.sb;
      p[0].rem <= '0;
      p[0].q <= head.ua;
      p[0].d <= head.ub;
    end
  end

  // product of the magnitudes in halves
  always_ff @(posedge clk) begin
    if (adv) begin
      ll <= p[0].q[HALF-1:0] * p[0].d[HALF-1:0];
      lh <= p[0].q[HALF-1:0] * p[0].d[XLEN-1:HALF];
      hl <= p[0].q[XLEN-1:HALF] * p[0].d[HALF-1:0];
      hh <= p[0].q[XLEN-1:HALF] * p[0].d[XLEN-1:HALF];
    end
  end

  logic [HALF+1:0] mid;
  assign mid = {2'b0, ll[XLEN-1:HALF]} + {2'b0, lh[HALF-1:0]} + {2'b0, hl[HALF-1:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      m_hi <= hh + {{HALF{1'b0}}, lh[XLEN-1:HALF]} + {{HALF{1'b0}}, hl[XLEN-1:HALF]}
              + {{(XLEN-2){1'b0}}, mid[HALF+1:HALF]};
      m_lo <= {mid[HALF-1:0], ll[HALF-1:0]};
    end
  end

  logic [XLEN-1:0] limit;
  logic            m_ovf;
  assign limit = p[2].neg ? {1'b1, {(XLEN-1){1'b0}}} : {1'b0, {(XLEN-1){1'b1}}};
  assign m_ovf = (m_hi != '0) || (m_lo > limit);

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [XLEN:0]   t;
    logic [XLEN:0]   s;
    logic            ge;
    stage_t          nxt;
    assign t = {p[k].rem, p[k].q[XLEN-1]};
    assign s = t - {1'b0, p[k].d};
    assign ge = !s[XLEN];
    always_comb begin
      nxt = p[k];
      nxt.rem = ge ? s[XLEN-1:0] : t[XLEN-1:0];
      nxt.q = {p[k].q[XLEN-2:0], ge};
      if (k == 2 && p[k].kind == KIND_MUL) begin
        nxt.kind = KIND_DONE;
        nxt.status = m_ovf ? ST_OVF : ST_OK;
        nxt.value = m_ovf ? '0 : (p[k].neg ? (~m_lo + 1'b1) : m_lo);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        p[k+1].valid <= 1'b0;
      end else if (adv) begin
        p[k+1].valid <= p[k].valid;
      end
      if (adv) begin
        p[k+1].kind <= nxt.kind;
        p[k+1].value <= nxt.value;
        p[k+1].status <= nxt.status;
        p[k+1].neg <= nxt.neg;
        p[k+1].sa <= nxt.sa;
        p[k+1].sb <= nxt.sb;
        p[k+1].rem <= nxt.rem;
        p[k+1].q <= nxt.q;
        p[k+1].d <= nxt.d;
      end
    end
  end

  // sign fixup of quotient and remainder, with quotient overflow check
  stage_t          fin;
  logic            qneg;
  always_comb begin
    fin = p[DIV_STEPS];
    qneg = p[DIV_STEPS].sa ^ p[DIV_STEPS].sb;
    case (p[DIV_STEPS].kind)
      KIND_DIV: begin
        if (!qneg && p[DIV_STEPS].q[XLEN-1]) begin
          fin.status = ST_OVF;
          fin.value = '0;
        end else begin
          fin.status = ST_OK;
          fin.value = qneg ? (~p[DIV_STEPS].q + 1'b1) : p[DIV_STEPS].q;
        end
      end
      KIND_REM: begin
        fin.status = ST_OK;
        fin.value = p[DIV_STEPS].sa ? (~p[DIV_STEPS].rem + 1'b1) : p[DIV_STEPS].rem;
      end
      default: fin.value = p[DIV_STEPS].value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p[LAST].valid <= 1'b0;
    end else if (adv) begin
      p[LAST].valid <= p[DIV_STEPS].valid;
    end
    if (adv) begin
      p[LAST].kind <= KIND_DONE;
      p[LAST].value <= fin.value;
      p[LAST].status <= fin.status;
      p[LAST].neg <= fin.neg;
      p[LAST].sa <= fin.sa;
      p[LAST].sb <= fin.sb;
      p[LAST].rem <= fin.rem;
      p[LAST].q <= fin.q;
      p[LAST].d <= fin.d;
    end
  end

endmodule
`default_nettype wire

FILE: src/cia_checker.sv
`default_nettype none
module cia_checker import cia_pkg::*; (
  input var logic clk,
  input var logic rst,
  input var logic push,
  input var logic full,
  input var logic pop,
  input var logic empty,
  input var out_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not empty after reset");

  a_status_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> result.value == '0)
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.status != 2'd3)
    else $error("bad status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(result))
    else $error("result changed while stalled");

  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("queue filled without a transfer in");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);
`default_nettype wire
